@@ design/fnv_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the FNV-1a word fingerprint.
// Depends on nothing; every other file of the block imports it.
package fnv_pkg;

  localparam int WORD_W         = 32;
  localparam int BYTE_W         = 8;
  localparam int FP_W           = 16;
  localparam int BYTES_PER_WORD = WORD_W / BYTE_W;
  localparam int CNT_W          = $clog2(BYTES_PER_WORD);

  localparam logic [WORD_W-1:0] FNV_BASIS = 32'd2166136261;
  localparam logic [WORD_W-1:0] FNV_PRIME = 32'd16777619;
  localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(BYTES_PER_WORD - 1);
  localparam logic [FP_W-1:0]   FP_ZERO   = '0;
  localparam logic [FP_W-1:0]   FP_ONE    = FP_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX,
    ST_FOLD
  } fnv_state_t;

  // Control bundle from the sequencer to the datapath.
  typedef struct packed {
    logic in_ready;
    logic capture;
    logic byte_from_in;
    logic mix_en;
    logic shift_en;
    logic load_basis;
    logic out_load;
  } fnv_ctl_t;

  // Folds the hash to 16 bits; zero is reserved and becomes one.
  function automatic logic [FP_W-1:0] fnv_fold(input logic [WORD_W-1:0] h);
    logic [FP_W-1:0] f;
    f = h[FP_W-1:0] ^ h[WORD_W-1:FP_W];
    return (f == FP_ZERO) ? FP_ONE : f;
  endfunction

endpackage

@@ design/fnv_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the word input and the fingerprint output.
// Depends on fnv_pkg for the field widths.
interface fnv_word_if;
  import fnv_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word;
  logic              last;

  modport source (output valid, output word, output last, input ready);
  modport sink   (input valid, input word, input last, output ready);
endinterface

interface fnv_print_if;
  import fnv_pkg::*;

  logic            valid;
  logic            ready;
  logic [FP_W-1:0] fingerprint;

  modport source (output valid, output fingerprint, input ready);
  modport sink   (input valid, input fingerprint, output ready);
endinterface

@@ design/fnv_mix.sv @@
`timescale 1ns / 1ps
// Shared byte-mix unit: holds the running hash and applies one XOR and
// multiply-by-prime step per enabled cycle. Depends on fnv_pkg.
module fnv_mix (
  input  logic                    clk,
  input  logic                    rst,
  input  fnv_pkg::fnv_ctl_t       ctl,
  input  logic [fnv_pkg::BYTE_W-1:0] mix_byte,
  output logic [fnv_pkg::WORD_W-1:0] hash
);
  import fnv_pkg::*;

  logic [WORD_W-1:0] hash_next;
  logic [WORD_W-1:0] mixed;

  // Product is taken modulo 2^32 by the 32-bit context.
  always_comb begin
    mixed     = hash ^ {{(WORD_W-BYTE_W){1'b0}}, mix_byte};
    hash_next = mixed * FNV_PRIME;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.load_basis) begin
      hash <= FNV_BASIS;
    end else if (ctl.mix_en) begin
      hash <= hash_next;
    end
  end

endmodule

@@ design/fnv_seq.sv @@
`timescale 1ns / 1ps
// Sequencer: steps the shared mix unit through the four bytes of a word and
// schedules the fold and output load. Depends on fnv_pkg.
module fnv_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  input  logic              out_free,
  output fnv_pkg::fnv_ctl_t ctl
);
  import fnv_pkg::*;

  fnv_state_t        state;
  fnv_state_t        state_next;
  logic [CNT_W-1:0]  cnt;
  logic              last_flag;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_MIX;
      end
      ST_MIX: begin
        if (cnt == CNT_LAST) state_next = last_flag ? ST_FOLD : ST_IDLE;
      end
      ST_FOLD: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state)
      ST_IDLE: begin
        ctl.in_ready     = 1'b1;
        ctl.capture      = in_valid;
        ctl.byte_from_in = 1'b1;
        ctl.mix_en       = in_valid;
      end
      ST_MIX: begin
        ctl.mix_en   = 1'b1;
        ctl.shift_en = 1'b1;
      end
      ST_FOLD: begin
        ctl.out_load   = out_free;
        ctl.load_basis = out_free;
      end
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      last_flag <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.capture) begin
        cnt       <= CNT_W'(1);
        last_flag <= in_last;
      end else if (ctl.mix_en) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

endmodule

@@ design/fnv1a_word_fingerprint.sv @@
`timescale 1ns / 1ps
// Top level of the FNV-1a word fingerprint: sequencer, shared mix unit,
// byte shift register and output register. Depends on fnv_pkg and fnv_if.
//
//  Channel  | Direction | Payload             | Transaction
//  ---------+-----------+---------------------+------------------------------
//  words    | sink      | word[31:0], last    | one word to mix into the hash
//  prints   | source    | fingerprint[15:0]   | folded hash after a last word
//
// The least significant byte of a word is mixed in the cycle the transaction
// is accepted, and the other three bytes follow one per cycle through the
// single shared multiply-by-prime unit. A word marked last adds a fold state,
// in which the fingerprint is loaded into the output register and
// the hash is reloaded with the offset basis. Reset is synchronous and returns
// the hash to the offset basis and the sequencer to idle. The output register
// decouples the two sides: new words are accepted while a fingerprint waits,
// and only the fold of the next last word stalls until that fingerprint is taken.
module fnv1a_word_fingerprint (
  input  logic        clk,
  input  logic        rst,
  fnv_word_if.sink    words,
  fnv_print_if.source prints
);
  import fnv_pkg::*;

  fnv_ctl_t          ctl;
  logic [WORD_W-1:0] hash;
  logic [WORD_W-1:0] word_sr;
  logic [BYTE_W-1:0] mix_byte;
  logic              out_free;
  logic              out_valid;
  logic [FP_W-1:0]   out_fp;

  // The output register is free when empty or being emptied this cycle.
  assign out_free = !out_valid || prints.ready;

  fnv_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (words.valid),
    .in_last  (words.last),
    .out_free (out_free),
    .ctl      (ctl)
  );

  // The first byte comes straight from the channel; the rest from the
  // shift register, which presents the next byte in its low bits.
  assign mix_byte = ctl.byte_from_in ? words.word[BYTE_W-1:0] : word_sr[BYTE_W-1:0];

  fnv_mix u_mix (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .mix_byte (mix_byte),
    .hash     (hash)
  );

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      word_sr <= words.word >> BYTE_W;
    end else if (ctl.shift_en) begin
      word_sr <= word_sr >> BYTE_W;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (prints.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_fp <= fnv_fold(hash);
    end
  end

  assign words.ready        = ctl.in_ready;
  assign prints.valid       = out_valid;
  assign prints.fingerprint = out_fp;

  // Once a word is taken, the channel stays closed while its remaining
  // three bytes go through the shared unit.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    words.valid && words.ready |=> !words.ready ##1 !words.ready ##1 !words.ready)
    else $error("word accepted while previous word still mixing");

  // The fingerprint never shows the reserved zero value.
  a_fp_nonzero: assert property (@(posedge clk) disable iff (rst)
    prints.valid |-> prints.fingerprint != FP_ZERO)
    else $error("fingerprint of zero presented");

  // Emitting a fingerprint always restarts the hash from the offset basis.
  a_basis_after_emit: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |=> hash == FNV_BASIS)
    else $error("hash not reloaded after fingerprint");

  // A fingerprint is never loaded over one that has not yet been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> !out_valid || prints.ready)
    else $error("output register overwritten");

endmodule

@@ tb/fnv1a_print_checker.sv @@
`timescale 1ns / 1ps
// Hash model and scoreboard for the FNV-1a word fingerprint testbench.
// Depends on fnv_pkg for widths and on fnv_if for the two channel interfaces.
package fnv_hash_model_pkg;
  import fnv_pkg::*;

  localparam logic [WORD_W-1:0] HASH_SEED  = 32'h811C_9DC5;
  localparam logic [WORD_W-1:0] HASH_PRIME = 32'h0100_0193;

  // Mixes the four bytes of one word into the hash, least significant first.
  function automatic logic [WORD_W-1:0] mix_word_into_hash(input logic [WORD_W-1:0] h,
                                                           input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] acc;
    acc = h;
    for (int i = 0; i < WORD_W / BYTE_W; i++) begin
      acc = (acc ^ {{(WORD_W - BYTE_W){1'b0}}, w[BYTE_W*i +: BYTE_W]}) * HASH_PRIME;
    end
    return acc;
  endfunction

  // Low half XOR high half, before zero is remapped.
  function automatic logic [FP_W-1:0] raw_fold(input logic [WORD_W-1:0] h);
    return h[FP_W-1:0] ^ h[WORD_W-1:FP_W];
  endfunction

  function automatic logic [FP_W-1:0] print_of_hash(input logic [WORD_W-1:0] h);
    logic [FP_W-1:0] f;
    f = raw_fold(h);
    return (f == '0) ? FP_W'(1) : f;
  endfunction
endpackage

module fnv1a_print_checker (
  input  logic  clk,
  input  logic  rst,
  fnv_word_if   words,
  fnv_print_if  prints,
  output int    errors,
  output int    pending,
  output int    compared
);
  import fnv_pkg::*;
  import fnv_hash_model_pkg::*;

  logic [WORD_W-1:0] running_hash;
  logic [FP_W-1:0]   prints_due[$];

  always @(posedge clk) begin
    logic [WORD_W-1:0] next_hash;
    logic [FP_W-1:0]   want;
    if (rst) begin
      running_hash = HASH_SEED;
      prints_due.delete();
      errors   <= 0;
      compared <= 0;
    end else begin
      // A fingerprint leaving now belongs to an earlier word, so retire it first.
      if (prints.valid && prints.ready) begin
        if (prints_due.size() == 0) begin
          $error("fingerprint: expected none, actual %h", prints.fingerprint);
          errors <= errors + 1;
        end else begin
          want = prints_due.pop_front();
          compared <= compared + 1;
          if (prints.fingerprint !== want) begin
            $error("fingerprint: expected %h, actual %h", want, prints.fingerprint);
            errors <= errors + 1;
          end
        end
      end
      if (words.valid && words.ready) begin
        next_hash = mix_word_into_hash(running_hash, words.word);
        if (words.last) begin
          prints_due.insert(prints_due.size(), print_of_hash(next_hash));
          running_hash = HASH_SEED;
        end else begin
          running_hash = next_hash;
        end
      end
    end
    pending <= prints_due.size();
  end
endmodule

@@ tb/fnv1a_word_fingerprint_tb.sv @@
`timescale 1ns / 1ps
// Top of the FNV-1a word fingerprint testbench: clock, reset, word stimulus,
// output back-pressure and verdict. Depends on fnv_pkg, fnv_if and the checker.
module fnv1a_word_fingerprint_tb;
  import fnv_pkg::*;
  import fnv_hash_model_pkg::*;

  // The cycle limit leaves ample headroom over the slowest honest run.
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_WORDS = 1450;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic steady = 1'b0;   // while high, neither side idles
  int   cycle_count = 0;
  int   errors;
  int   pending;
  int   compared;
  int   words_sent = 0;
  int   sets_sent = 0;
  int   zero_fold_sets = 0;

  fnv_word_if  words_ch();
  fnv_print_if prints_ch();

  fnv1a_word_fingerprint u_top (
    .clk    (clk),
    .rst    (rst),
    .words  (words_ch),
    .prints (prints_ch)
  );

  fnv1a_print_checker u_chk (
    .clk      (clk),
    .rst      (rst),
    .words    (words_ch),
    .prints   (prints_ch),
    .errors   (errors),
    .pending  (pending),
    .compared (compared)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run guard: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d fingerprints outstanding",
               cycle_count, pending);
      $display("fnv1a_word_fingerprint_tb: errors");
      $finish;
    end
  end

  // The receiver stalls in roughly a quarter of cycles, except during the steady
  // stretch, so that the output register is held across every phase of the fold.
  always @(posedge clk) begin
    if (rst) begin
      prints_ch.ready <= 1'b0;
    end else begin
      prints_ch.ready <= steady || ($urandom_range(0, 99) >= 24);
    end
  end

  // Presents one word and returns at the edge where the transaction is taken.
  // Before presenting, the sender may drop valid for a short random gap; the
  // gap lengths vary so that idle cycles land on the mix of each byte and on
  // the fold.
  task automatic send_word(input logic [WORD_W-1:0] w, input logic is_last);
    if (!steady && $urandom_range(0, 99) < 24) begin
      words_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    words_ch.valid <= 1'b1;
    words_ch.word  <= w;
    words_ch.last  <= is_last;
    do @(posedge clk); while (!words_ch.ready);
    words_sent++;
    if (is_last) sets_sent++;
  endtask

  // Word content is biased towards the edges of the 32-bit range: all zeros,
  // all ones, single set or cleared bits and small two's complement values.
  function automatic logic [WORD_W-1:0] pick_word();
    logic [WORD_W-1:0] one_hot;
    one_hot = WORD_W'(1) << $urandom_range(0, WORD_W - 1);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return one_hot;
      3: return ~one_hot;
      4: return -WORD_W'($urandom_range(1, 256));
      5: return WORD_W'($urandom_range(0, 255));
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [WORD_W-1:0] zero_fold_word;
    logic              found;
    int unsigned       cand;
    int                set_len;
    int                set_no;

    words_ch.valid = 1'b0;
    words_ch.word  = '0;
    words_ch.last  = 1'b0;

    // Find a single-word set whose folded hash is zero, so that the mapping of
    // zero to one is exercised. The search takes no simulated time.
    found = 1'b0;
    zero_fold_word = '0;
    for (cand = 0; cand < 32'h0100_0000 && !found; cand++) begin
      if (raw_fold(mix_word_into_hash(HASH_SEED, cand)) == '0) begin
        zero_fold_word = cand;
        found = 1'b1;
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: one-word sets at the extremes of the word, the zero-fold
    // case, and multi-word sets that carry extreme and signed values.
    send_word(32'h0000_0000, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b1);
    send_word(32'h8000_0000, 1'b1);
    send_word(32'h7FFF_FFFF, 1'b1);
    send_word(32'h0000_0001, 1'b1);
    if (found) begin
      send_word(zero_fold_word, 1'b1);
      zero_fold_sets++;
    end
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h7FFF_FFFF, 1'b0);
    send_word(32'h8000_0000, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'hFFFF_FFFE, 1'b1);
    send_word(32'hA5A5_A5A5, 1'b0);
    send_word(32'h5A5A_5A5A, 1'b0);
    send_word(32'h0123_4567, 1'b0);
    send_word(32'h89AB_CDEF, 1'b1);
    if (found) begin
      send_word(zero_fold_word, 1'b1);
      zero_fold_sets++;
    end

    // Random part: whole sets, mostly short, some long, with the odd zero-fold
    // set mixed in. A stretch of sets runs with both sides never idling.
    set_no = 0;
    while (words_sent < RANDOM_WORDS + 20) begin
      steady <= (set_no >= 60 && set_no < 110);
      if (found && $urandom_range(0, 49) == 0) begin
        send_word(zero_fold_word, 1'b1);
        zero_fold_sets++;
      end else begin
        case ($urandom_range(0, 19))
          0:        set_len = $urandom_range(31, 80);
          1, 2, 3:  set_len = $urandom_range(7, 30);
          default:  set_len = $urandom_range(1, 6);
        endcase
        for (int i = 0; i < set_len; i++) begin
          send_word(pick_word(), i == set_len - 1);
        end
      end
      set_no++;
    end

    words_ch.valid <= 1'b0;
    steady <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // The pending count covers fingerprints still in the fold; this wait catches any extra one.
    repeat (30) @(posedge clk);

    $display("Covered %0d words in %0d sets (%0d with a zero fold); %0d fingerprints compared",
             words_sent, sets_sent, zero_fold_sets, compared);
    if (errors == 0) begin
      $display("fnv1a_word_fingerprint_tb: clean");
    end else begin
      $display("fnv1a_word_fingerprint_tb: errors");
    end
    $finish;
  end
endmodule
